FILE: sv/pqt_pkg.sv
// Shared types and codes for the predecessor query table.
package pqt_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned RecW   = 3 * FieldW;

  typedef enum logic [0:0] {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STS_ADDED  = 2'd0,
    STS_FULL   = 2'd1,
    STS_FOUND  = 2'd2,
    STS_NOBODY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] score_key;
    logic signed [31:0] record_id;
    logic        [31:0] payload_tag;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] found_score;
    logic signed [31:0] found_id;
    logic        [31:0] found_tag;
  } out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] id;
    logic        [31:0] tag;
  } rec_t;

endpackage

FILE: sv/pqt_ram.sv
// Generic simple dual-port RAM with registered read.
module pqt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/predecessor_query_table.sv
// Predecessor query table: add records, find the greatest score strictly below a threshold.
// An add passes from acceptance through the emit state to the result register; a query
// with N stored records walks them (none with an empty table) with the single comparator,
// reading the record RAM one entry per cycle. Throughput: one item at a time; the next is
// accepted once the current result is registered, which waits while the output stalls.
// Synchronous active-low reset empties the table (entry count zero), drops any result.
module predecessor_query_table
  import pqt_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer and control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            issue_r, issue_nxt;     // a read goes to the RAM this cycle
  logic            cmp_vld_r, cmp_vld_nxt; // RAM read data holds a record to compare
  logic            out_valid_r, out_valid_nxt;

  // Working payload
  action_t            op_r, op_nxt;
  status_t            status_r, status_nxt;
  logic signed [31:0] limit_r, limit_nxt;
  logic               have_r, have_nxt;
  rec_t               best_r, best_nxt;
  out_t               out_r, out_nxt;

  // RAM port
  logic          ram_we;
  logic          ram_re;
  rec_t          ram_wdata;
  logic [RecW-1:0] ram_rdata;
  rec_t          rd_rec;

  logic          last_addr;
  logic          below;
  logic          better;
  out_t          result;

  pqt_ram #(
    .WIDTH (RecW),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = '{key: in_data.score_key, id: in_data.record_id,
                       tag: in_data.payload_tag};
  assign rd_rec    = rec_t'(ram_rdata);

  // Last stored entry reached: stop issuing reads after this one
  assign last_addr = (CW'(addr_r) + CW'(1)) == count_r;

  // The shared comparator: candidate lies below the threshold and beats the best so far.
  // Equal score and id go to the later entry, since entries arrive in insertion order.
  assign below  = rd_rec.key < limit_r;
  assign better = !have_r || (rd_rec.key > best_r.key) ||
                  ((rd_rec.key == best_r.key) && (rd_rec.id >= best_r.id));

  // Assemble the result word from the finished operation
  always_comb begin
    result = '{status: STS_NOBODY, found_score: '0, found_id: '0, found_tag: '0};
    if (op_r == ACT_ADD) begin
      result.status = status_r;
    end else if (have_r) begin
      result.status      = STS_FOUND;
      result.found_score = best_r.key;
      result.found_id    = best_r.id;
      result.found_tag   = best_r.tag;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = cmp_vld_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    limit_nxt     = limit_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.action;
          limit_nxt = in_data.score_key;
          if (in_data.action == ACT_ADD) begin
            // Append at the fill point, or drop when full
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = STS_FULL;
            end else begin
              status_nxt = STS_ADDED;
              ram_we     = 1'b1;
              count_nxt  = count_r + CW'(1);
            end
            state_nxt = ST_EMIT;
          end else begin
            have_nxt = 1'b0;
            addr_nxt = '0;
            if (count_r == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              issue_nxt = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; compare the record read the cycle before
        cmp_vld_nxt = issue_r;
        if (issue_r) begin
          ram_re = 1'b1;
          if (last_addr) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
        if (cmp_vld_r && below && better) begin
          have_nxt = 1'b1;
          best_nxt = rd_rec;
        end
        if (!issue_r && !cmp_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = result;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    limit_r  <= limit_nxt;
    have_r   <= have_nxt;
    best_r   <= best_nxt;
    out_r    <= out_nxt;
  end

  // Fill count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // Fill count moves only on an accepted add
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && (in_data.action == ACT_ADD)) |=> $stable(count_r))
    else $error("entry count changed without an add");

  // No transfer accepted during a sweep
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_ready)
    else $error("input ready during a sweep");

  // A drained sweep always moves on to emit its result
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && !issue_r && !cmp_vld_r |=> (state_r == ST_EMIT))
    else $error("sweep did not finish");

endmodule

FILE: tb/predecessor_query_table_tb.sv
// Self-checking testbench for the predecessor query table: directed and random adds and queries.
module predecessor_query_table_tb;
  import pqt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned RANDOM_ITEMS = 1875;
  // Run limit: every item as a full-table query, plus stalls, taken several times over
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  // Tracks the table contents and the answers that the block owes, oldest first.
  class answer_board;
    logic signed [31:0] key_tab[];
    logic signed [31:0] id_tab[];
    logic        [31:0] tag_tab[];
    int unsigned        filled;
    int unsigned        depth;
    int unsigned        errors;
    out_t               pending_answers[$];

    function new(int unsigned table_depth);
      depth   = table_depth;
      key_tab = new[table_depth];
      id_tab  = new[table_depth];
      tag_tab = new[table_depth];
      filled  = 0;
      errors  = 0;
    endfunction

    // Apply an accepted item to the table copy and queue the answer it must produce.
    function void note_item(in_t item);
      out_t               ans;
      logic signed [31:0] limit;
      logic signed [31:0] best_key;
      logic signed [31:0] best_id;
      int unsigned        best_idx;
      bit                 have;
      ans      = '0;
      limit    = item.score_key;
      best_key = '0;
      best_id  = '0;
      best_idx = 0;
      have     = 1'b0;
      if (item.action == ACT_ADD) begin
        if (filled >= depth) begin
          ans.status = STS_FULL;
        end else begin
          key_tab[filled] = item.score_key;
          id_tab[filled]  = item.record_id;
          tag_tab[filled] = item.payload_tag;
          filled++;
          ans.status = STS_ADDED;
        end
      end else begin
        for (int unsigned i = 0; i < filled; i++) begin
          if (key_tab[i] < limit) begin
            // later entries take ties on both score and id
            if (!have || key_tab[i] > best_key ||
                (key_tab[i] == best_key && id_tab[i] >= best_id)) begin
              have     = 1'b1;
              best_key = key_tab[i];
              best_id  = id_tab[i];
              best_idx = i;
            end
          end
        end
        if (have) begin
          ans.status      = STS_FOUND;
          ans.found_score = key_tab[best_idx];
          ans.found_id    = id_tab[best_idx];
          ans.found_tag   = tag_tab[best_idx];
        end else begin
          ans.status = STS_NOBODY;
        end
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(out_t got);
      out_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, status %0d score %0d id %0d tag %h",
                 $time, got.status, got.found_score, got.found_id, got.found_tag);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.found_score !== want.found_score) begin
        $display("%0t: found_score mismatch, expected %0d, actual %0d",
                 $time, want.found_score, got.found_score);
        errors++;
      end
      if (got.found_id !== want.found_id) begin
        $display("%0t: found_id mismatch, expected %0d, actual %0d",
                 $time, want.found_id, got.found_id);
        errors++;
      end
      if (got.found_tag !== want.found_tag) begin
        $display("%0t: found_tag mismatch, expected %h, actual %h",
                 $time, want.found_tag, got.found_tag);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  answer_board board;
  bit          no_idle;   // suppress random idling on both sides
  bit          hold_req;  // ask the receiver for one long hold-off

  predecessor_query_table #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run overstays the limit; a hung handshake ends here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("predecessor_query_table test failed");
    $finish;
  end

  // Receiver: decide out_ready at each falling edge. A hold-off request takes
  // priority over random idling and is counted down here, one cycle at a time.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 14);
      end
    end
  end

  // Check each result transfer at the rising edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_answer(out_data);
    end
  end

  function automatic in_t make_item(action_t act, logic signed [31:0] score,
                                    logic signed [31:0] rid, logic [31:0] tag);
    in_t item;
    item.action      = act;
    item.score_key   = score;
    item.record_id   = rid;
    item.payload_tag = tag;
    return item;
  endfunction

  // Mostly a narrow band so that scores collide, with extremes and full-range values mixed in.
  function automatic logic signed [31:0] rand_score();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      return $signed($urandom_range(16)) - 8;
    end else if (roll < 70) begin
      case ($urandom_range(3))
        0:       return S_MIN;
        1:       return S_MIN + 1;
        2:       return S_MAX;
        default: return S_MAX - 1;
      endcase
    end else if (roll < 85) begin
      return $signed($urandom_range(2000)) - 1000;
    end else begin
      return $urandom;
    end
  endfunction

  // Offer one item, entered and left at a falling edge. Idle first at random, then
  // hold valid and payload steady until the transfer happens.
  task automatic send_item(input in_t item);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(item);
    @(negedge clk);
  endtask

  initial begin
    in_t               item;
    logic signed [31:0] rid;
    board    = new(TABLE_DEPTH);
    no_idle  = 1'b0;
    hold_req = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table queries, the extremes of every field, and the tie rules.
    send_item(make_item(ACT_QUERY, 32'sd0, 32'sd0, 32'h0));
    send_item(make_item(ACT_QUERY, S_MAX, S_MAX, 32'hffff_ffff));
    send_item(make_item(ACT_ADD, S_MIN, 32'sd5, 32'h0));
    // nothing lies strictly below the smallest score
    send_item(make_item(ACT_QUERY, S_MIN, 32'sd0, 32'h0));
    send_item(make_item(ACT_QUERY, S_MIN + 1, 32'sd0, 32'h0));
    send_item(make_item(ACT_ADD, 32'sd100, 32'sd3, 32'hffff_ffff));
    send_item(make_item(ACT_ADD, 32'sd100, 32'sd7, 32'h0000_0001));
    // same score and id again: the newer record must win
    send_item(make_item(ACT_ADD, 32'sd100, 32'sd7, 32'h0000_0002));
    send_item(make_item(ACT_ADD, 32'sd100, S_MIN, 32'h8000_0000));
    send_item(make_item(ACT_QUERY, 32'sd101, 32'sd0, 32'h0));
    send_item(make_item(ACT_QUERY, 32'sd100, 32'sd0, 32'h0));
    send_item(make_item(ACT_ADD, S_MAX, S_MAX, 32'hffff_ffff));
    send_item(make_item(ACT_QUERY, S_MAX, 32'sd0, 32'h0));
    send_item(make_item(ACT_ADD, -32'sd1, -32'sd1, 32'haaaa_aaaa));
    send_item(make_item(ACT_QUERY, 32'sd0, S_MIN, 32'h5555_5555));
    send_item(make_item(ACT_ADD, 32'sd50, 32'sh5555_5555, 32'h5555_5555));
    send_item(make_item(ACT_ADD, 32'sd50, S_MAX, 32'h1234_5678));
    send_item(make_item(ACT_QUERY, 32'sd99, 32'sd0, 32'h0));
    send_item(make_item(ACT_QUERY, -32'sd1, 32'sd0, 32'h0));
    send_item(make_item(ACT_QUERY, 32'sh7fff_fffe, 32'sd0, 32'h0));

    // Random: about a third adds, so the table fills part-way through and
    // later adds meet the full table while queries walk every entry.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 600);
      if (n == 700) begin
        hold_req = 1'b1;
      end
      if ($urandom_range(99) < 50) begin
        rid = $signed($urandom_range(6)) - 3;
      end else begin
        rid = $urandom;
      end
      item = make_item(action_t'(($urandom_range(99) < 35) ? ACT_ADD : ACT_QUERY),
                       rand_score(), rid, $urandom);
      send_item(item);
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // Drain, then keep watching for anything stray to show up.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("predecessor_query_table test passed");
    end else begin
      $display("predecessor_query_table test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pqt_pkg.sv
sv/pqt_ram.sv
sv/predecessor_query_table.sv
tb/predecessor_query_table_tb.sv
